// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dmatrig_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA trigger controller package
// Transaction layouts, register window layout and field codes.
// ----------------------------------------------------------------------------
package dmatrig_pkg;

  // Operation carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_e;

  // Register access width codes
  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;

  // Video phase codes
  localparam logic [1:0] PHASE_DRAW   = 2'd0;
  localparam logic [1:0] PHASE_HBLANK = 2'd1;
  localparam logic [1:0] PHASE_VBLANK = 2'd2;

  // Start timing codes
  localparam logic [1:0] TIMING_NOW    = 2'd0;
  localparam logic [1:0] TIMING_VBLANK = 2'd1;
  localparam logic [1:0] TIMING_HBLANK = 2'd2;

  // Address modes
  localparam logic [1:0] MODE_INC = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;

  // Window layout: three 32-bit words per channel (SAD, DAD, CNT_H:CNT_L)
  localparam int NUM_CH       = 4;
  localparam int WORDS_PER_CH = 3;
  localparam int NUM_WORDS    = NUM_CH * WORDS_PER_CH;
  localparam int W_SAD        = 0;
  localparam int W_DAD        = 1;
  localparam int W_CNT        = 2;
  localparam logic [3:0] WIN_WORDS = 4'd12;

  // Control halfword bit positions
  localparam int CTL_DMODE  = 5;
  localparam int CTL_SMODE  = 7;
  localparam int CTL_REPEAT = 9;
  localparam int CTL_WORD   = 10;
  localparam int CTL_TIMING = 12;
  localparam int CTL_IRQ    = 14;
  localparam int CTL_ENABLE = 15;

  // Count widths and zero-count substitutes
  localparam logic [16:0] COUNT_MAX_NARROW = 17'h04000;
  localparam logic [16:0] COUNT_MAX_WIDE   = 17'h10000;

  typedef struct packed {
    func_e       func;
    logic [5:0]  reg_offset;
    logic [1:0]  access_width;
    logic [31:0] write_data;
    logic [1:0]  display_phase;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        started;
    logic [1:0]  chan;
    logic [31:0] src_start;
    logic [31:0] dst_start;
    logic [16:0] unit_count;
    logic        word_units;
    logic [1:0]  src_mode;
    logic [1:0]  dst_mode;
    logic        irq_request;
  } out_item_t;

endpackage

// ===== hw/rtl/four_channel_dma_trigger_controller.sv =====
// ----------------------------------------------------------------------------
// Four-channel DMA trigger controller
// Path: one input stage register, then one result register, to the master side.
// Throughput: one transaction per cycle unless the master side stalls; the
//   four channels are evaluated in parallel in one pass.
// Reset: asynchronous, active low; register window, latches, enable history
//   and last phase clear to zero (drawing) at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_channel_dma_trigger_controller
  import dmatrig_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: [5:0] reg_offset, [7:6] access_width, [39:8] write_data,
  //        [41:40] display_phase, [47:42] zero
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,
  // tuser: [1:0] func
  input  logic [1:0]   s_axis_tuser,
  // tdata: [31:0] read_data, [33:32] chan, [65:34] src_start, [97:66] dst_start,
  //        [114:98] unit_count, [115] word_units, [117:116] src_mode,
  //        [119:118] dst_mode, [120] irq_request, [127:121] zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  // tuser: [0] started
  output logic         m_axis_tuser
);

  // Input stage and result register
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      advance;

  // Architectural state
  logic [NUM_WORDS-1:0][31:0] words_q, words_d;
  logic [NUM_CH-1:0]          seen_q, seen_d;
  logic [NUM_CH-1:0][31:0]    src_q, src_d;
  logic [NUM_CH-1:0][31:0]    dst_q, dst_d;
  logic [NUM_CH-1:0][15:0]    cnt_q, cnt_d;
  logic [1:0]                 last_phase_q, last_phase_d;

  // Handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Capture input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.func          <= func_e'(s_axis_tuser);
      in_q.reg_offset    <= s_axis_tdata[5:0];
      in_q.access_width  <= s_axis_tdata[7:6];
      in_q.write_data    <= s_axis_tdata[39:8];
      in_q.display_phase <= s_axis_tdata[41:40];
    end
  end

  // Register access decode: word index, byte lane and enables
  logic [3:0]  word_idx;
  logic        in_win;
  logic [1:0]  lane;
  logic [3:0]  byte_en;
  logic [31:0] rd_mask;
  logic [31:0] rd_word;
  logic [31:0] rd_value;
  logic [31:0] wr_shifted;

  assign word_idx = in_q.reg_offset[5:2];
  assign in_win   = (word_idx < WIN_WORDS);

  always_comb begin
    case (in_q.access_width)
      WIDTH_BYTE: begin
        lane    = in_q.reg_offset[1:0];
        byte_en = 4'b0001 << in_q.reg_offset[1:0];
        rd_mask = 32'h0000_00FF;
      end
      WIDTH_HALF: begin
        lane    = {in_q.reg_offset[1], 1'b0};
        byte_en = 4'b0011 << {in_q.reg_offset[1], 1'b0};
        rd_mask = 32'h0000_FFFF;
      end
      default: begin
        lane    = 2'b00;
        byte_en = 4'b1111;
        rd_mask = 32'hFFFF_FFFF;
      end
    endcase
  end

  assign rd_word    = in_win ? words_q[word_idx] : 32'h0;
  assign rd_value   = (rd_word >> {lane, 3'b000}) & rd_mask;
  assign wr_shifted = in_q.write_data << {lane, 3'b000};

  // Per-channel view: enable edge, fresh latch values, eligibility
  logic [NUM_CH-1:0][15:0] ctl;
  logic [NUM_CH-1:0]       rise;
  logic [NUM_CH-1:0]       elig;
  logic [NUM_CH-1:0][31:0] src_cur, dst_cur;
  logic [NUM_CH-1:0][15:0] cnt_cur;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ctl[c]     = words_q[c*WORDS_PER_CH + W_CNT][31:16];
      rise[c]    = !seen_q[c] && ctl[c][CTL_ENABLE];
      src_cur[c] = rise[c] ? words_q[c*WORDS_PER_CH + W_SAD] : src_q[c];
      dst_cur[c] = rise[c] ? words_q[c*WORDS_PER_CH + W_DAD] : dst_q[c];
      cnt_cur[c] = rise[c] ? words_q[c*WORDS_PER_CH + W_CNT][15:0] : cnt_q[c];
      case (ctl[c][CTL_TIMING +: 2])
        TIMING_NOW: begin
          elig[c] = ctl[c][CTL_ENABLE];
        end
        TIMING_VBLANK: begin
          elig[c] = ctl[c][CTL_ENABLE] && (last_phase_q != PHASE_VBLANK) &&
                    (in_q.display_phase == PHASE_VBLANK);
        end
        TIMING_HBLANK: begin
          elig[c] = ctl[c][CTL_ENABLE] && (last_phase_q != PHASE_HBLANK) &&
                    (in_q.display_phase == PHASE_HBLANK);
        end
        default: begin
          elig[c] = ctl[c][CTL_ENABLE] && (c == NUM_CH - 1);
        end
      endcase
    end
  end

  // Pick the lowest eligible channel
  logic [1:0] sel;
  logic       any_elig;

  always_comb begin
    sel = 2'd0;
    for (int c = NUM_CH - 1; c >= 0; c--) begin
      if (elig[c]) begin
        sel = 2'(c);
      end
    end
  end
  assign any_elig = |elig;

  // Descriptor of the selected channel
  logic [15:0] sel_ctl;
  logic [15:0] sel_cnt_raw;
  logic [16:0] sel_count;
  logic [31:0] span;
  logic [1:0]  sel_smode, sel_dmode;
  logic        sel_word;
  logic        clear_en;

  assign sel_ctl     = ctl[sel];
  assign sel_cnt_raw = cnt_cur[sel];
  assign sel_smode   = sel_ctl[CTL_SMODE +: 2];
  assign sel_dmode   = sel_ctl[CTL_DMODE +: 2];
  assign sel_word    = sel_ctl[CTL_WORD];
  assign clear_en    = !sel_ctl[CTL_REPEAT] || (sel_ctl[CTL_TIMING +: 2] == TIMING_NOW);

  always_comb begin
    if (sel == 2'(NUM_CH - 1)) begin
      sel_count = (sel_cnt_raw == 16'h0) ? COUNT_MAX_WIDE : {1'b0, sel_cnt_raw};
    end else begin
      sel_count = (sel_cnt_raw[13:0] == 14'h0) ? COUNT_MAX_NARROW
                                               : {3'b000, sel_cnt_raw[13:0]};
    end
  end

  assign span = sel_word ? {13'h0, sel_count, 2'b00} : {14'h0, sel_count, 1'b0};

  // Next state and result
  always_comb begin
    words_d      = words_q;
    seen_d       = seen_q;
    src_d        = src_q;
    dst_d        = dst_q;
    cnt_d        = cnt_q;
    last_phase_d = last_phase_q;
    out_d        = '0;

    case (in_q.func)
      FUNC_READ: begin
        out_d.read_data = rd_value;
      end
      FUNC_WRITE: begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (in_win && (word_idx == 4'(w))) begin
            for (int b = 0; b < 4; b++) begin
              if (byte_en[b]) begin
                words_d[w][8*b +: 8] = wr_shifted[8*b +: 8];
              end
            end
          end
        end
      end
      FUNC_UPDATE: begin
        last_phase_d = in_q.display_phase;
        for (int c = 0; c < NUM_CH; c++) begin
          seen_d[c] = ctl[c][CTL_ENABLE];
          src_d[c]  = src_cur[c];
          dst_d[c]  = dst_cur[c];
          cnt_d[c]  = cnt_cur[c];
          if (any_elig && (sel == 2'(c))) begin
            // Advance stored addresses past the transfer
            if (sel_smode == MODE_INC) begin
              src_d[c] = src_cur[c] + span;
            end else if (sel_smode == MODE_DEC) begin
              src_d[c] = src_cur[c] - span;
            end
            if (sel_dmode == MODE_INC) begin
              dst_d[c] = dst_cur[c] + span;
            end else if (sel_dmode == MODE_DEC) begin
              dst_d[c] = dst_cur[c] - span;
            end
            // Drop enable for one-shot transfers and for immediate-timing starts
            if (clear_en) begin
              words_d[c*WORDS_PER_CH + W_CNT][16 + CTL_ENABLE] = 1'b0;
            end
          end
        end
        if (any_elig) begin
          out_d.started     = 1'b1;
          out_d.chan        = sel;
          out_d.src_start   = src_cur[sel];
          out_d.dst_start   = dst_cur[sel];
          out_d.unit_count  = sel_count;
          out_d.word_units  = sel_word;
          out_d.src_mode    = sel_smode;
          out_d.dst_mode    = sel_dmode;
          out_d.irq_request = sel_ctl[CTL_IRQ];
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  // Update state on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q      <= '0;
      seen_q       <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      cnt_q        <= '0;
      last_phase_q <= PHASE_DRAW;
    end else if (advance) begin
      words_q      <= words_d;
      seen_q       <= seen_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      cnt_q        <= cnt_d;
      last_phase_q <= last_phase_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Drive master side
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.started;
  assign m_axis_tdata  = {7'h00, out_q.irq_request, out_q.dst_mode, out_q.src_mode,
                          out_q.word_units, out_q.unit_count, out_q.dst_start,
                          out_q.src_start, out_q.chan, out_q.read_data};

  // Checks
  `ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "processed transaction lost")
  `ASSERT_IMPL(a_start_descriptor, out_valid_q && out_q.started, (out_q.read_data == 32'h0) && (out_q.unit_count != 17'h0), "bad start descriptor")
  `ASSERT_NEXT(a_read_keeps_window, advance && (in_q.func == FUNC_READ), $stable(words_q), "register read changed window")

endmodule

// ===== tb/sv/four_channel_dma_trigger_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-channel DMA trigger controller testbench
// Drives register reads and writes and update events into the slave stream
// and predicts every result in a model of the register window, channel
// latches and video phase history kept here. Each result on the master stream
// is compared field by field with the oldest prediction. Both sides idle at
// random.
// ----------------------------------------------------------------------------
module four_channel_dma_trigger_controller_tb
  import dmatrig_pkg::*;
();

  // Codes the package leaves unnamed
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam logic [1:0] WIDTH_WORD  = 2'd2;
  localparam logic [1:0] WIDTH_CODE3 = 2'd3;
  localparam logic [1:0] PHASE_ODD   = 2'd3;
  localparam logic [1:0] TIMING_CH3  = 2'd3;
  localparam logic [1:0] MODE_FIXED  = 2'd2;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  // Window layout in bytes
  localparam int WIN_BYTES = NUM_WORDS * 4;
  localparam int CH_BYTES  = WORDS_PER_CH * 4;
  localparam int OFF_SAD   = W_SAD * 4;
  localparam int OFF_DAD   = W_DAD * 4;
  localparam int OFF_CNT   = W_CNT * 4;
  localparam int OFF_CTL   = OFF_CNT + 2;
  localparam int RANDOM_ITEMS = 750;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  four_channel_dma_trigger_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's state
  logic [7:0]  win_mem [WIN_BYTES];
  logic        en_hist [NUM_CH];
  logic [31:0] src_ptr [NUM_CH];
  logic [31:0] dst_ptr [NUM_CH];
  logic [15:0] cnt_latched [NUM_CH];
  logic [1:0]  prev_phase;

  out_item_t   pending_results [$];
  out_item_t   exp_r;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned items_counted;
  int unsigned results_seen;
  int unsigned starts_per_ch [NUM_CH];
  int unsigned burst_left;
  logic [15:0] stall_mask;
  int unsigned stall_pos;

  initial begin
    foreach (win_mem[i]) win_mem[i] = '0;
    foreach (en_hist[i]) begin
      en_hist[i]     = 1'b0;
      src_ptr[i]     = '0;
      dst_ptr[i]     = '0;
      cnt_latched[i] = '0;
      starts_per_ch[i] = 0;
    end
    prev_phase = PHASE_DRAW;
  end

  // Compute the result of one transaction and advance the shadow state
  function automatic out_item_t dma_predict(logic [1:0] func, logic [5:0] off,
                                            logic [1:0] wd, logic [31:0] data,
                                            logic [1:0] phase);
    out_item_t   res;
    int          nbytes;
    int          addr;
    int          base;
    int          i;
    logic [15:0] ctl;
    logic [1:0]  timing;
    logic [16:0] units;
    logic [31:0] span;
    bit          fired;
    bit          ok;
    res = '0;
    nbytes = (wd == WIDTH_BYTE) ? 1 : (wd == WIDTH_HALF) ? 2 : 4;
    addr = int'(off) & ~(nbytes - 1);
    case (func)
      FUNC_READ: begin
        if (addr < WIN_BYTES)
          for (i = 0; i < nbytes; i++) res.read_data |= 32'(win_mem[addr + i]) << (8 * i);
      end
      FUNC_WRITE: begin
        if (addr < WIN_BYTES)
          for (i = 0; i < nbytes; i++) win_mem[addr + i] = data[8 * i +: 8];
      end
      FUNC_UPDATE: begin
        // latch addresses and count on a rising enable
        for (i = 0; i < NUM_CH; i++) begin
          base = i * CH_BYTES;
          if (!en_hist[i] && win_mem[base + OFF_CTL + 1][CTL_ENABLE - 8]) begin
            src_ptr[i] = {win_mem[base + OFF_SAD + 3], win_mem[base + OFF_SAD + 2],
                          win_mem[base + OFF_SAD + 1], win_mem[base + OFF_SAD]};
            dst_ptr[i] = {win_mem[base + OFF_DAD + 3], win_mem[base + OFF_DAD + 2],
                          win_mem[base + OFF_DAD + 1], win_mem[base + OFF_DAD]};
            cnt_latched[i] = {win_mem[base + OFF_CNT + 1], win_mem[base + OFF_CNT]};
          end
          en_hist[i] = win_mem[base + OFF_CTL + 1][CTL_ENABLE - 8];
        end
        // start the lowest eligible channel
        fired = 1'b0;
        for (i = 0; i < NUM_CH && !fired; i++) begin
          base = i * CH_BYTES;
          ctl = {win_mem[base + OFF_CTL + 1], win_mem[base + OFF_CTL]};
          timing = ctl[CTL_TIMING +: 2];
          ok = 1'b0;
          if (ctl[CTL_ENABLE]) begin
            case (timing)
              TIMING_NOW:    ok = 1'b1;
              TIMING_VBLANK: ok = prev_phase != PHASE_VBLANK && phase == PHASE_VBLANK;
              TIMING_HBLANK: ok = prev_phase != PHASE_HBLANK && phase == PHASE_HBLANK;
              default:       ok = (i == NUM_CH - 1);
            endcase
          end
          if (ok) begin
            fired = 1'b1;
            if (!ctl[CTL_REPEAT] || timing == TIMING_NOW)
              win_mem[base + OFF_CTL + 1][CTL_ENABLE - 8] = 1'b0;
            if (i == NUM_CH - 1)
              units = (cnt_latched[i] == '0) ? COUNT_MAX_WIDE : {1'b0, cnt_latched[i]};
            else
              units = (cnt_latched[i][13:0] == '0) ? COUNT_MAX_NARROW
                                                    : {3'b000, cnt_latched[i][13:0]};
            span = 32'(units) << (ctl[CTL_WORD] ? 2 : 1);
            res.started     = 1'b1;
            res.chan        = 2'(i);
            res.src_start   = src_ptr[i];
            res.dst_start   = dst_ptr[i];
            res.unit_count  = units;
            res.word_units  = ctl[CTL_WORD];
            res.src_mode    = ctl[CTL_SMODE +: 2];
            res.dst_mode    = ctl[CTL_DMODE +: 2];
            res.irq_request = ctl[CTL_IRQ];
            if (res.src_mode == MODE_INC) src_ptr[i] = src_ptr[i] + span;
            else if (res.src_mode == MODE_DEC) src_ptr[i] = src_ptr[i] - span;
            if (res.dst_mode == MODE_INC) dst_ptr[i] = dst_ptr[i] + span;
            else if (res.dst_mode == MODE_DEC) dst_ptr[i] = dst_ptr[i] - span;
          end
        end
        prev_phase = phase;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] ctl_word(logic [1:0] dmode, logic [1:0] smode, logic rpt,
                                           logic wide, logic [1:0] timing, logic irq,
                                           logic en);
    logic [15:0] v;
    v = '0;
    v[CTL_DMODE +: 2]  = dmode;
    v[CTL_SMODE +: 2]  = smode;
    v[CTL_REPEAT]      = rpt;
    v[CTL_WORD]        = wide;
    v[CTL_TIMING +: 2] = timing;
    v[CTL_IRQ]         = irq;
    v[CTL_ENABLE]      = en;
    return v;
  endfunction

  // Send one transaction in bursts separated by random gaps
  task automatic send_item(logic [1:0] func, logic [5:0] off, logic [1:0] wd,
                           logic [31:0] data, logic [1:0] phase);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, phase, data, wd, off};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(dma_predict(func, off, wd, data, phase));
    items_sent++;
    if (func != FUNC_NONE && !(func == FUNC_WRITE && off >= WIN_BYTES)) items_counted++;
  endtask

  task automatic write_reg(int off, logic [1:0] wd, logic [31:0] data);
    send_item(FUNC_WRITE, 6'(off), wd, data, 2'($urandom_range(0, 3)));
  endtask

  task automatic read_reg(int off, logic [1:0] wd);
    send_item(FUNC_READ, 6'(off), wd, $urandom, 2'($urandom_range(0, 3)));
  endtask

  task automatic run_update(logic [1:0] phase);
    send_item(FUNC_UPDATE, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)), $urandom,
              phase);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
              2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)));
  endtask

  // Byte store: widths, alignment, width code three, out of window, unknown op
  task automatic test_register_window();
    write_reg(0, WIDTH_WORD, 32'hFFFF_FFFF);
    read_reg(3, WIDTH_BYTE);
    write_reg(5, WIDTH_HALF, 32'h1234_ABCD);
    read_reg(6, WIDTH_CODE3);
    write_reg(47, WIDTH_BYTE, 32'h0000_0025);
    read_reg(46, WIDTH_HALF);
    write_reg(48, WIDTH_WORD, 32'hDEAD_BEEF);
    read_reg(63, WIDTH_WORD);
    send_item(FUNC_NONE, 6'd20, WIDTH_WORD, 32'hFFFF_FFFF, PHASE_ODD);
  endtask

  // Every timing, zero counts, repeat, priority and the undefined phase code
  task automatic test_transfer_starts();
    write_reg(OFF_SAD, WIDTH_WORD, 32'h0200_0000);
    write_reg(OFF_DAD, WIDTH_WORD, 32'h0300_0000);
    write_reg(OFF_CNT, WIDTH_WORD,
              {ctl_word(MODE_DEC, MODE_INC, 1'b0, 1'b1, TIMING_NOW, 1'b1, 1'b1), 16'h0000});
    run_update(PHASE_DRAW);
    write_reg(CH_BYTES + OFF_SAD, WIDTH_WORD, 32'hFFFF_FFFE);
    write_reg(CH_BYTES + OFF_DAD, WIDTH_WORD, 32'h0000_0001);
    write_reg(CH_BYTES + OFF_CNT, WIDTH_WORD,
              {ctl_word(MODE_FIXED, MODE_DEC, 1'b1, 1'b0, TIMING_VBLANK, 1'b1, 1'b1),
               16'hFFFF});
    run_update(PHASE_DRAW);
    run_update(PHASE_VBLANK);
    run_update(PHASE_VBLANK);
    write_reg(3 * CH_BYTES + OFF_SAD, WIDTH_WORD, 32'h8000_0000);
    write_reg(3 * CH_BYTES + OFF_CNT, WIDTH_WORD,
              {ctl_word(MODE_RELOAD, MODE_INC, 1'b1, 1'b1, TIMING_CH3, 1'b0, 1'b1),
               16'h0000});
    run_update(PHASE_ODD);
    run_update(PHASE_HBLANK);
    write_reg(2 * CH_BYTES + OFF_CNT, WIDTH_WORD,
              {ctl_word(MODE_INC, MODE_INC, 1'b0, 1'b0, TIMING_HBLANK, 1'b0, 1'b1),
               16'h0001});
    run_update(PHASE_DRAW);
    run_update(PHASE_HBLANK);
  endtask

  // Program one channel with random content, then walk the video phase
  task automatic program_channel();
    int unsigned c;
    int unsigned base;
    int unsigned k;
    logic [31:0] sad;
    logic [31:0] dad;
    logic [15:0] cnt;
    logic [15:0] ctl;
    c = $urandom_range(0, NUM_CH - 1);
    base = c * CH_BYTES;
    sad = $urandom;
    dad = $urandom;
    case ($urandom_range(0, 3))
      0: cnt = 16'h0000;
      1: cnt = 16'hFFFF;
      2: cnt = 16'($urandom_range(1, 16));
      default: cnt = 16'($urandom);
    endcase
    ctl = ctl_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7) != 0);
    ctl = ctl | (16'($urandom) & 16'h081F);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(base + OFF_SAD, WIDTH_HALF, {16'($urandom), sad[15:0]});
      write_reg(base + OFF_SAD + 2, WIDTH_HALF, {16'($urandom), sad[31:16]});
    end else begin
      write_reg(base + OFF_SAD, WIDTH_WORD, sad);
    end
    write_reg(base + OFF_DAD, ($urandom_range(0, 5) == 0) ? WIDTH_CODE3 : WIDTH_WORD, dad);
    case ($urandom_range(0, 2))
      0: write_reg(base + OFF_CNT, WIDTH_WORD, {ctl, cnt});
      1: begin
        write_reg(base + OFF_CNT, WIDTH_HALF, {16'($urandom), cnt});
        write_reg(base + OFF_CTL, WIDTH_HALF, {16'($urandom), ctl});
      end
      default: begin
        write_reg(base + OFF_CNT, WIDTH_HALF, {16'($urandom), cnt});
        write_reg(base + OFF_CTL, WIDTH_BYTE, {24'($urandom), ctl[7:0]});
        write_reg(base + OFF_CTL + 1, WIDTH_BYTE, {24'($urandom), ctl[15:8]});
      end
    endcase
    for (k = 0; k < $urandom_range(1, 6); k++) begin
      run_update(($urandom_range(0, 15) == 0) ? PHASE_ODD : 2'($urandom_range(0, 2)));
      if ($urandom_range(0, 4) == 0) read_reg($urandom_range(0, WIN_BYTES - 1),
                                              2'($urandom_range(0, 3)));
    end
  endtask

  // Mostly well-formed channel programming, the rest raw noise
  task automatic test_random_traffic();
    int unsigned start_count;
    start_count = items_counted;
    while (items_counted - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) program_channel();
      else repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  task automatic check_field(string name, logic [31:0] expd, logic [31:0] act);
    if (expd !== act) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, expd, act);
    end
  endtask

  // Check each result transaction and drive the receiver's stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("read_data",   exp_r.read_data,   m_axis_tdata[31:0]);
        check_field("started",     32'(exp_r.started), 32'(m_axis_tuser));
        check_field("chan",        32'(exp_r.chan),   32'(m_axis_tdata[33:32]));
        check_field("src_start",   exp_r.src_start,   m_axis_tdata[65:34]);
        check_field("dst_start",   exp_r.dst_start,   m_axis_tdata[97:66]);
        check_field("unit_count",  32'(exp_r.unit_count), 32'(m_axis_tdata[114:98]));
        check_field("word_units",  32'(exp_r.word_units), 32'(m_axis_tdata[115]));
        check_field("src_mode",    32'(exp_r.src_mode), 32'(m_axis_tdata[117:116]));
        check_field("dst_mode",    32'(exp_r.dst_mode), 32'(m_axis_tdata[119:118]));
        check_field("irq_request", 32'(exp_r.irq_request), 32'(m_axis_tdata[120]));
        if (exp_r.started) starts_per_ch[exp_r.chan]++;
      end
    end
    m_axis_tready <= !stall_mask[stall_pos];
    stall_pos++;
    if (stall_pos == 16) begin
      stall_pos = 0;
      case ($urandom_range(0, 3))
        0: stall_mask = 16'h0000;
        1: stall_mask = 16'($urandom);
        2: stall_mask = 16'hFFF0;
        default: stall_mask = 16'h0101 << $urandom_range(0, 7);
      endcase
    end
  end

  initial begin
    int unsigned drain_cycles;
    error_count   = 0;
    items_sent    = 0;
    items_counted = 0;
    results_seen  = 0;
    burst_left    = 0;
    stall_mask    = '0;
    stall_pos     = 0;
    drain_cycles  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_window();
    test_transfer_starts();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, pending_results.size());
    end

    $display("Covered %0d input transactions and %0d checked results with random stalls.",
             items_sent, results_seen);
    $display("Transfers started per channel: %0d %0d %0d %0d, field mismatches: %0d",
             starts_per_ch[0], starts_per_ch[1], starts_per_ch[2], starts_per_ch[3],
             error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dmatrig_pkg.sv
hw/rtl/four_channel_dma_trigger_controller.sv
tb/sv/four_channel_dma_trigger_controller_tb.sv
